// ----- design/tti_pkg.sv -----
// Shared types and constants of the thermistor table interpolation unit.
package tti_pkg;

   localparam int RAW_WIDTH       = 15;
   localparam int CEL_WIDTH       = 16;
   localparam int ENTRY_WIDTH     = RAW_WIDTH + CEL_WIDTH;
   localparam int TEMP_WIDTH      = 20;
   localparam int CHANNEL_WIDTH   = 2;
   localparam int INDEX_WIDTH     = 6;
   localparam int COUNT_WIDTH     = 7;
   localparam int REG_COUNT       = 4;
   localparam int REG_INDEX_WIDTH = 2;
   localparam int WRITABLE_LIMIT  = 64;
   localparam int MIN_ENTRIES     = 2;
   localparam int COUNT_RESET     = 2;
   localparam int OUT_MIN         = -524288;
   localparam int OUT_MAX         = 524287;

   // signed sample delta times signed celsius delta
   localparam int PROD_WIDTH      = (RAW_WIDTH + 1) + (CEL_WIDTH + 1);
   // magnitude of that product always fits here
   localparam int PROD_MAG_WIDTH  = RAW_WIDTH + CEL_WIDTH;

   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   typedef struct packed {
      logic [RAW_WIDTH-1:0]        raw;
      logic signed [CEL_WIDTH-1:0] celsius;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [2:0] {
      TTI_IDLE,
      TTI_SCAN,
      TTI_DIFF,
      TTI_MULT,
      TTI_MAG,
      TTI_DIVIDE,
      TTI_SUM,
      TTI_OUTPUT
   } tti_state_type;

endpackage

// ----- design/tti_req_if.sv -----
// Request channel: table writes and convert commands.
interface tti_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic [tti_pkg::CHANNEL_WIDTH-1:0]   channel;
   logic [tti_pkg::INDEX_WIDTH-1:0]     entry_index;
   logic [tti_pkg::RAW_WIDTH-1:0]       entry_raw;
   logic signed [tti_pkg::CEL_WIDTH-1:0] entry_celsius;
   logic [tti_pkg::RAW_WIDTH-1:0]       sample_raw;

   modport source (
      output valid, command, channel, entry_index, entry_raw, entry_celsius, sample_raw,
      input  ready
   );
   modport sink (
      input  valid, command, channel, entry_index, entry_raw, entry_celsius, sample_raw,
      output ready
   );
endinterface

// ----- design/tti_rsp_if.sv -----
// Response channel: converted temperature and flags.
interface tti_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tti_pkg::TEMP_WIDTH-1:0] temp_sixteenths;
   logic                                  beyond_table;
   logic                                  result_clipped;

   modport source (
      output valid, temp_sixteenths, beyond_table, result_clipped,
      input  ready
   );
   modport sink (
      input  valid, temp_sixteenths, beyond_table, result_clipped,
      output ready
   );
endinterface

// ----- design/tti_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tti_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 256,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_address,
   input  logic [WIDTH-1:0]      write_data,
   input  logic [ADDR_WIDTH-1:0] read_address,
   output logic [WIDTH-1:0]      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

// ----- design/tti_divider.sv -----
// Restoring divider, one quotient bit per cycle, unsigned operands.
module tti_divider #(
   parameter int DIVIDEND_WIDTH = 35,
   localparam int COUNT_W = $clog2(DIVIDEND_WIDTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DIVIDEND_WIDTH-1:0]       dividend,
   input  logic [tti_pkg::RAW_WIDTH-1:0]   divisor,
   output tti_pkg::div_status_type         status,
   output logic [DIVIDEND_WIDTH-1:0]       quotient
);

   localparam int RW = tti_pkg::RAW_WIDTH;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [RW-1:0]             rem_ff, rem_in;
   logic [RW-1:0]             divisor_ff, divisor_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [RW:0]               trial;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quo_in     = quo_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = COUNT_W'(DIVIDEND_WIDTH);
         rem_in     = '0;
         divisor_in = divisor;
         quo_in     = dividend;
      end else if (busy_ff) begin
         rem_in   = fits ? RW'(trial - {1'b0, divisor_ff}) : trial[RW-1:0];
         quo_in   = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         count_in = count_ff - COUNT_W'(1);
         if (count_ff == COUNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quo_ff     <= quo_in;
   end

   assign status   = {busy_ff, done_ff};
   assign quotient = quo_ff;

endmodule

// ----- design/thermistor_table_interpolation_unit.sv -----
// Thermistor table interpolation unit. Each channel owns a table of ascending
// (raw, celsius) entries held in one RAM of CHANNELS x TABLE_DEPTH words. A write
// transfer stores one entry in a single cycle and gives no response. A convert
// transfer walks the channel's table one entry per cycle from entry 0 until the
// first entry after entry 0 whose raw value exceeds the sample, then interpolates
// from the entry before it with one multiply and a restoring divider that makes
// one quotient bit per cycle (31 + FRACTION_BITS bits). After the walk an
// interpolation steps through the DIFF, MULT, MAG, DIVIDE and SUM states; from
// OUTPUT it loads the response register and raises rsp.valid once that register
// is free. A sample at or above the last entry returns that entry's value after
// the walk alone, with beyond_table set. The result is in 1/2^FRACTION_BITS
// degree, quotient truncated toward zero, saturated to 20 bits; result_clipped
// marks saturation, a non-ascending segment, or a channel that is not present.
// req.ready is high only when the sequencer is idle; a finished result waits in
// the response register and does not block new transfers until the next result
// is ready to leave. Entry counts come from the csr registers (2..64, clamped)
// and must only be changed while the unit is idle. The table RAM has no reset;
// entries must be written before they are converted.
module thermistor_table_interpolation_unit #(
   parameter int TABLE_DEPTH   = 64,
   parameter int CHANNELS      = 4,
   parameter int FRACTION_BITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tti_pkg::REG_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tti_pkg::COUNT_WIDTH-1:0]       csr_write_data,
   tti_req_if.sink                               req,
   tti_rsp_if.source                             rsp
);

   localparam int STORE_DEPTH = CHANNELS * TABLE_DEPTH;
   localparam int AW          = $clog2(STORE_DEPTH);
   localparam int ENTRY_LIMIT = (TABLE_DEPTH < tti_pkg::WRITABLE_LIMIT) ?
                                TABLE_DEPTH : tti_pkg::WRITABLE_LIMIT;
   localparam int DIVIDEND_W  = tti_pkg::PROD_MAG_WIDTH + FRACTION_BITS;
   localparam int SUM_W       = DIVIDEND_W + 2;
   localparam int RW          = tti_pkg::RAW_WIDTH;
   localparam int CW          = tti_pkg::CEL_WIDTH;
   localparam int PW          = tti_pkg::PROD_WIDTH;
   localparam int IW          = tti_pkg::INDEX_WIDTH;
   localparam int TW          = tti_pkg::TEMP_WIDTH;
   localparam logic signed [SUM_W-1:0] SAT_LOW  = SUM_W'(tti_pkg::OUT_MIN);
   localparam logic signed [SUM_W-1:0] SAT_HIGH = SUM_W'(tti_pkg::OUT_MAX);

   function automatic logic signed [SUM_W-1:0] scale_cel(input logic signed [CW-1:0] c);
      scale_cel = SUM_W'(c) <<< FRACTION_BITS;
   endfunction

   function automatic logic [AW-1:0] entry_addr(input logic [tti_pkg::CHANNEL_WIDTH-1:0] ch,
                                                input logic [IW-1:0] idx);
      entry_addr = AW'(int'(ch) * TABLE_DEPTH + int'(idx));
   endfunction

   // entry counts
   logic [tti_pkg::COUNT_WIDTH-1:0] entries_ff [tti_pkg::REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < tti_pkg::REG_COUNT; k++) begin
            entries_ff[k] <= tti_pkg::COUNT_WIDTH'(tti_pkg::COUNT_RESET);
         end
      end else if (csr_write_enable) begin
         entries_ff[csr_index] <= csr_write_data;
      end
   end

   // sequencer state
   tti_pkg::tti_state_type          state_ff, state_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [IW-1:0]                   last_ff, last_in;
   logic [AW-1:0]                   base_ff, base_in;
   logic [RW-1:0]                   sample_ff, sample_in;
   tti_pkg::entry_type              prev_ff, prev_in;
   tti_pkg::entry_type              hi_ff, hi_in;
   logic signed [RW:0]              dsample_ff, dsample_in;
   logic signed [CW:0]              dc_ff, dc_in;
   logic [RW-1:0]                   divisor_ff, divisor_in;
   logic signed [PW-1:0]            prod_ff, prod_in;
   logic                            neg_ff, neg_in;
   logic signed [SUM_W-1:0]         acc_ff, acc_in;
   logic                            clip_ff, clip_in;
   logic                            beyond_ff, beyond_in;

   // response register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [TW-1:0]            temp_ff, temp_in;
   logic                            rsp_beyond_ff, rsp_beyond_in;
   logic                            rsp_clip_ff, rsp_clip_in;

   // table RAM
   logic                            ram_we;
   logic [AW-1:0]                   ram_waddr;
   logic [AW-1:0]                   ram_raddr;
   logic [tti_pkg::ENTRY_WIDTH-1:0] ram_rdata;
   tti_pkg::entry_type              rd_entry;

   // divider
   logic                            div_start;
   logic [DIVIDEND_W-1:0]           div_dividend;
   logic [DIVIDEND_W-1:0]           div_quotient;
   tti_pkg::div_status_type         div_status;

   logic                            accept;
   logic signed [PW-1:0]            prod_abs;
   logic [SUM_W-1:0]                q_ext;
   int                              n_req;

   assign req.ready = (state_ff == tti_pkg::TTI_IDLE);
   assign accept    = req.valid && req.ready;
   assign rd_entry  = tti_pkg::entry_type'(ram_rdata);
   assign prod_abs  = prod_ff[PW-1] ? -prod_ff : prod_ff;
   assign div_dividend = DIVIDEND_W'(prod_abs[tti_pkg::PROD_MAG_WIDTH-1:0]) << FRACTION_BITS;
   assign q_ext     = SUM_W'(div_quotient);

   // write port fed straight from the request
   assign ram_waddr = entry_addr(req.channel, req.entry_index);
   assign ram_we    = accept && (req.command == tti_pkg::CMD_WRITE) &&
                      (int'(req.channel) < CHANNELS) && (int'(req.entry_index) < TABLE_DEPTH);

   // clamped entry count of the requested channel
   always_comb begin
      n_req = int'(entries_ff[req.channel]);
      if (n_req < tti_pkg::MIN_ENTRIES) begin
         n_req = tti_pkg::MIN_ENTRIES;
      end else if (n_req > ENTRY_LIMIT) begin
         n_req = ENTRY_LIMIT;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      base_in       = base_ff;
      sample_in     = sample_ff;
      prev_in       = prev_ff;
      hi_in         = hi_ff;
      dsample_in    = dsample_ff;
      dc_in         = dc_ff;
      divisor_in    = divisor_ff;
      prod_in       = prod_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      clip_in       = clip_ff;
      beyond_in     = beyond_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      temp_in       = temp_ff;
      rsp_beyond_in = rsp_beyond_ff;
      rsp_clip_in   = rsp_clip_ff;
      div_start     = 1'b0;
      // read ahead one entry during the walk, stay on the last one
      ram_raddr     = (idx_ff == last_ff) ? base_ff + AW'(idx_ff)
                                          : base_ff + AW'(idx_ff) + AW'(1);

      case (state_ff)
         tti_pkg::TTI_IDLE: begin
            ram_raddr = entry_addr(req.channel, '0);
            if (accept && (req.command == tti_pkg::CMD_CONVERT)) begin
               idx_in    = '0;
               last_in   = IW'(n_req - 1);
               base_in   = entry_addr(req.channel, '0);
               sample_in = req.sample_raw;
               beyond_in = 1'b0;
               clip_in   = 1'b0;
               if (int'(req.channel) >= CHANNELS) begin
                  acc_in   = '0;
                  clip_in  = 1'b1;
                  state_in = tti_pkg::TTI_OUTPUT;
               end else begin
                  state_in = tti_pkg::TTI_SCAN;
               end
            end
         end
         tti_pkg::TTI_SCAN: begin
            if (idx_ff == '0) begin
               prev_in = rd_entry;
               idx_in  = IW'(1);
            end else if (rd_entry.raw > sample_ff) begin
               hi_in    = rd_entry;
               state_in = tti_pkg::TTI_DIFF;
            end else if (idx_ff == last_ff) begin
               acc_in    = scale_cel(rd_entry.celsius);
               beyond_in = 1'b1;
               state_in  = tti_pkg::TTI_OUTPUT;
            end else begin
               prev_in = rd_entry;
               idx_in  = idx_ff + IW'(1);
            end
         end
         tti_pkg::TTI_DIFF: begin
            if (hi_ff.raw <= prev_ff.raw) begin
               // flat or descending segment
               acc_in   = scale_cel(prev_ff.celsius);
               clip_in  = 1'b1;
               state_in = tti_pkg::TTI_OUTPUT;
            end else begin
               dsample_in = $signed({1'b0, sample_ff}) - $signed({1'b0, prev_ff.raw});
               dc_in      = (CW + 1)'(hi_ff.celsius) - (CW + 1)'(prev_ff.celsius);
               divisor_in = hi_ff.raw - prev_ff.raw;
               state_in   = tti_pkg::TTI_MULT;
            end
         end
         tti_pkg::TTI_MULT: begin
            prod_in  = PW'(dsample_ff) * PW'(dc_ff);
            state_in = tti_pkg::TTI_MAG;
         end
         tti_pkg::TTI_MAG: begin
            neg_in    = prod_ff[PW-1];
            div_start = 1'b1;
            state_in  = tti_pkg::TTI_DIVIDE;
         end
         tti_pkg::TTI_DIVIDE: begin
            if (div_status.done) begin
               state_in = tti_pkg::TTI_SUM;
            end
         end
         tti_pkg::TTI_SUM: begin
            acc_in   = scale_cel(prev_ff.celsius) + (neg_ff ? -q_ext : q_ext);
            state_in = tti_pkg::TTI_OUTPUT;
         end
         tti_pkg::TTI_OUTPUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_beyond_in = beyond_ff;
               if (acc_ff < SAT_LOW) begin
                  temp_in     = TW'(tti_pkg::OUT_MIN);
                  rsp_clip_in = 1'b1;
               end else if (acc_ff > SAT_HIGH) begin
                  temp_in     = TW'(tti_pkg::OUT_MAX);
                  rsp_clip_in = 1'b1;
               end else begin
                  temp_in     = acc_ff[TW-1:0];
                  rsp_clip_in = clip_ff;
               end
               state_in = tti_pkg::TTI_IDLE;
            end
         end
         default: begin
            state_in = tti_pkg::TTI_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tti_pkg::TTI_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      base_ff       <= base_in;
      sample_ff     <= sample_in;
      prev_ff       <= prev_in;
      hi_ff         <= hi_in;
      dsample_ff    <= dsample_in;
      dc_ff         <= dc_in;
      divisor_ff    <= divisor_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      acc_ff        <= acc_in;
      clip_ff       <= clip_in;
      beyond_ff     <= beyond_in;
      temp_ff       <= temp_in;
      rsp_beyond_ff <= rsp_beyond_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   tti_ram #(
      .WIDTH (tti_pkg::ENTRY_WIDTH),
      .DEPTH (STORE_DEPTH)
   ) u_table (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    ({req.entry_raw, req.entry_celsius}),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   tti_divider #(
      .DIVIDEND_WIDTH (DIVIDEND_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (divisor_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.temp_sixteenths = temp_ff;
   assign rsp.beyond_table    = rsp_beyond_ff;
   assign rsp.result_clipped  = rsp_clip_ff;

   // divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // divider completion only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == tti_pkg::TTI_DIVIDE))
      else $error("divider done outside divide state");

   // table walk stays within the entries in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tti_pkg::TTI_SCAN) |-> (idx_ff <= last_ff))
      else $error("table walk beyond last entry");

   // a table write never produces a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.command == tti_pkg::CMD_WRITE)) |=>
         ((state_ff == tti_pkg::TTI_IDLE) && !$rose(rsp.valid)))
      else $error("table write produced a response");

endmodule
